// ----- rtl/csl_pkg.sv -----
package csl_pkg;

	localparam int unsigned MAX_TOKEN_COUNT_DEF = 1024;

	typedef struct packed {
		logic [7:0] src_byte;
		logic       end_of_source;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  tok_kind;
		logic [7:0]  tok_code;
		logic [15:0] start_line;
		logic [23:0] start_offset;
		logic [7:0]  tok_length;
		logic [9:0]  tok_index;
		logic        last_of_run;
	} out_item_t;

	// token kinds
	localparam logic [2:0] KIND_NUM   = 3'd0;
	localparam logic [2:0] KIND_IDENT = 3'd1;
	localparam logic [2:0] KIND_KW    = 3'd2;
	localparam logic [2:0] KIND_OP    = 3'd3;
	localparam logic [2:0] KIND_SYM   = 3'd4;
	localparam logic [2:0] KIND_ERR   = 3'd5;

	// operator codes
	localparam logic [7:0] OP_ADD    = 8'd0;
	localparam logic [7:0] OP_SUB    = 8'd1;
	localparam logic [7:0] OP_MUL    = 8'd2;
	localparam logic [7:0] OP_DIV    = 8'd3;
	localparam logic [7:0] OP_ASSIGN = 8'd4;
	localparam logic [7:0] OP_LT     = 8'd5;
	localparam logic [7:0] OP_GT     = 8'd6;
	localparam logic [7:0] OP_EQ     = 8'd7;
	localparam logic [7:0] OP_LE     = 8'd8;
	localparam logic [7:0] OP_GE     = 8'd9;

	// symbol codes
	localparam logic [7:0] SYM_SEMI   = 8'd0;
	localparam logic [7:0] SYM_LBRACE = 8'd1;
	localparam logic [7:0] SYM_RBRACE = 8'd2;
	localparam logic [7:0] SYM_LPAREN = 8'd3;
	localparam logic [7:0] SYM_RPAREN = 8'd4;

	// keyword codes
	localparam logic [2:0] KW_INT    = 3'd0;
	localparam logic [2:0] KW_RETURN = 3'd1;
	localparam logic [2:0] KW_IF     = 3'd2;
	localparam logic [2:0] KW_ELSE   = 3'd3;
	localparam logic [2:0] KW_WHILE  = 3'd4;
	localparam logic [2:0] KW_NONE   = 3'd5;

	// prefix holds first char in the low byte, so the text reads reversed
	localparam logic [47:0] KW_INT_PFX    = {24'd0, "tni"};
	localparam logic [47:0] KW_RETURN_PFX = "nruter";
	localparam logic [47:0] KW_IF_PFX     = {32'd0, "fi"};
	localparam logic [47:0] KW_ELSE_PFX   = {16'd0, "esle"};
	localparam logic [47:0] KW_WHILE_PFX  = {8'd0, "elihw"};

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b inside {8'h20, [8'h09:8'h0D]};
	endfunction

	function automatic logic [2:0] keyword_code(input logic [47:0] pfx, input logic [7:0] len);
		logic [2:0] k;
		k = KW_NONE;
		if (len == 8'd3 && pfx == KW_INT_PFX) k = KW_INT;
		if (len == 8'd6 && pfx == KW_RETURN_PFX) k = KW_RETURN;
		if (len == 8'd2 && pfx == KW_IF_PFX) k = KW_IF;
		if (len == 8'd4 && pfx == KW_ELSE_PFX) k = KW_ELSE;
		if (len == 8'd5 && pfx == KW_WHILE_PFX) k = KW_WHILE;
		return k;
	endfunction

	function automatic logic [7:0] cmp_code(input logic [7:0] c, input logic with_eq);
		logic [7:0] r;
		case (c)
			"=": r = with_eq ? OP_EQ : OP_ASSIGN;
			"<": r = with_eq ? OP_LE : OP_LT;
			default: r = with_eq ? OP_GE : OP_GT;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/c_subset_lexer.sv -----
// Channel  Dir  Payload     Handshake
// src      in   in_item_t   src_valid / src_stall, one source byte per transfer
// tok      out  out_item_t  tok_valid / tok_stall, one token per transfer
//
// One byte per cycle while the input is not stalled. A byte goes into the input
// register, is scanned in the next cycle and its tokens (zero, one or two) land
// in a four-entry result queue that drives the output port.
// The single result port moves one token per cycle while tok_stall is low, so
// bytes that close one token and make another take two transfers; the input
// stalls while the queue holds more than two tokens.
// Reset clears scan state, counters and the queue; line starts at 1.
module c_subset_lexer #(
	parameter int unsigned MAX_TOKEN_COUNT = csl_pkg::MAX_TOKEN_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  csl_pkg::in_item_t  src_data,
	output logic               tok_valid,
	input  logic               tok_stall,
	output csl_pkg::out_item_t tok_data
);
	import csl_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_TOKEN_COUNT + 1);

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_NUM   = 3'd1,
		M_IDENT = 3'd2,
		M_CMP   = 3'd3,
		M_SLASH = 3'd4,
		M_LINEC = 3'd5,
		M_BLOCK = 3'd6,
		M_STAR  = 3'd7
	} mode_t;

	// token before the table limit and index are applied
	typedef struct packed {
		logic        vld;
		logic [2:0]  kind;
		logic [7:0]  code;
		logic [15:0] line;
		logic [23:0] off;
		logic [7:0]  len;
	} raw_tok_t;

	// report whatever token the given mode holds open
	function automatic raw_tok_t pend_tok(input mode_t m, input logic [7:0] pch,
			input logic [15:0] sline, input logic [23:0] soff,
			input logic [7:0] len, input logic [47:0] pfx);
		raw_tok_t t;
		logic [2:0] k;
		k = keyword_code(pfx, len);
		t = '{vld: 1'b1, kind: KIND_NUM, code: 8'd0, line: sline, off: soff, len: len};
		case (m)
			M_NUM: t.kind = KIND_NUM;
			M_IDENT: begin
				if (k != KW_NONE) begin
					t.kind = KIND_KW;
					t.code = 8'(k);
				end else begin
					t.kind = KIND_IDENT;
				end
			end
			M_CMP: begin
				t.kind = KIND_OP;
				t.code = cmp_code(pch, 1'b0);
			end
			M_SLASH: begin
				t.kind = KIND_OP;
				t.code = OP_DIV;
			end
			default: t.vld = 1'b0;
		endcase
		return t;
	endfunction

	// input register
	logic     valid_s1;
	in_item_t item_s1;
	logic     adv;

	// scan state
	mode_t       mode_q;
	logic [7:0]  pch_q;
	logic [15:0] line_q;
	logic [23:0] off_q;
	logic [23:0] soff_q;
	logic [15:0] sline_q;
	logic [7:0]  len_q;
	logic [47:0] pfx_q;
	logic [CNT_W-1:0] cnt_q;

	// result queue
	out_item_t  q_mem [4];
	logic [1:0] head_q, tail_q;
	logic [2:0] count_q;

	// after the byte itself
	mode_t       mode_a;
	logic [7:0]  pch_a;
	logic [15:0] line_a;
	logic [23:0] soff_a;
	logic [15:0] sline_a;
	logic [7:0]  len_a;
	logic [47:0] pfx_a;
	logic        do_idle;
	raw_tok_t    flush_old, t_a, t_b, t_c;

	logic [7:0] b;
	logic       eos;

	raw_tok_t         cand [3];
	out_item_t        res0, res1;
	logic [1:0]       n_res;
	logic [CNT_W-1:0] cnt_run;
	logic             keep, is_err;
	out_item_t        cur;
	logic             pop;

	assign b   = item_s1.src_byte;
	assign eos = item_s1.end_of_source;

	assign adv       = valid_s1 && (count_q <= 3'd2);
	assign src_stall = valid_s1 && !adv;
	assign tok_valid = (count_q != 3'd0);
	assign tok_data  = q_mem[head_q];
	assign pop       = tok_valid && !tok_stall;

	assign flush_old = pend_tok(mode_q, pch_q, sline_q, soff_q, len_q, pfx_q);

	// scan one byte against the current mode
	always_comb begin
		mode_a  = mode_q;
		pch_a   = pch_q;
		line_a  = line_q;
		soff_a  = soff_q;
		sline_a = sline_q;
		len_a   = len_q;
		pfx_a   = pfx_q;
		t_a     = '0;
		t_b     = '0;
		do_idle = 1'b0;

		case (mode_q)
			M_NUM: begin
				if (is_digit(b)) begin
					len_a = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
				end else begin
					t_a     = flush_old;
					do_idle = 1'b1;
				end
			end
			M_IDENT: begin
				if (is_alpha(b) || is_digit(b)) begin
					if (len_q < 8'd6) pfx_a[8*len_q[2:0] +: 8] = b;
					len_a = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
				end else begin
					t_a     = flush_old;
					do_idle = 1'b1;
				end
			end
			M_CMP: begin
				if (b == "=") begin
					t_a    = '{vld: 1'b1, kind: KIND_OP, code: cmp_code(pch_q, 1'b1),
						line: sline_q, off: soff_q, len: 8'd2};
					mode_a = M_IDLE;
				end else begin
					t_a     = flush_old;
					do_idle = 1'b1;
				end
			end
			M_SLASH: begin
				if (b == "/") begin
					mode_a = M_LINEC;
				end else if (b == "*") begin
					mode_a = M_BLOCK;
				end else begin
					t_a     = flush_old;
					do_idle = 1'b1;
				end
			end
			M_LINEC: begin
				if (b == 8'h0A) do_idle = 1'b1;
			end
			M_BLOCK: begin
				if (b == "*") begin
					mode_a = M_STAR;
				end else if (b == 8'h0A) begin
					line_a = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;
				end
			end
			M_STAR: begin
				if (b == "/") begin
					mode_a = M_IDLE;
				end else if (b != "*") begin
					if (b == 8'h0A) line_a = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;
					mode_a = M_BLOCK;
				end
			end
			default: do_idle = 1'b1;
		endcase

		// byte seen with nothing open
		if (do_idle) begin
			mode_a = M_IDLE;
			if (is_space(b)) begin
				if (b == 8'h0A) line_a = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;
			end else if (is_digit(b) || is_alpha(b) || b == "=" || b == "<" || b == ">"
					|| b == "/") begin
				soff_a  = off_q;
				sline_a = line_q;
				len_a   = 8'd1;
				if (is_digit(b)) begin
					mode_a = M_NUM;
				end else if (is_alpha(b)) begin
					mode_a = M_IDENT;
					pfx_a  = {40'd0, b};
				end else if (b == "/") begin
					mode_a = M_SLASH;
				end else begin
					mode_a = M_CMP;
					pch_a  = b;
				end
			end else begin
				t_b = '{vld: 1'b1, kind: KIND_OP, code: OP_ADD, line: line_q, off: off_q,
					len: 8'd1};
				case (b)
					"+": t_b.code = OP_ADD;
					"-": t_b.code = OP_SUB;
					"*": t_b.code = OP_MUL;
					";": begin t_b.kind = KIND_SYM; t_b.code = SYM_SEMI; end
					"{": begin t_b.kind = KIND_SYM; t_b.code = SYM_LBRACE; end
					"}": begin t_b.kind = KIND_SYM; t_b.code = SYM_RBRACE; end
					"(": begin t_b.kind = KIND_SYM; t_b.code = SYM_LPAREN; end
					")": begin t_b.kind = KIND_SYM; t_b.code = SYM_RPAREN; end
					default: begin t_b.kind = KIND_ERR; t_b.code = b; end
				endcase
			end
		end

		// end of source flushes what is still open; comments just drop
		t_c = eos ? pend_tok(mode_a, pch_a, sline_a, soff_a, len_a, pfx_a) : '0;
	end

	// table limit, indexes and packing into at most two results
	always_comb begin
		cand[0] = t_a;
		cand[1] = t_b;
		cand[2] = t_c;
		res0    = '0;
		res1    = '0;
		n_res   = 2'd0;
		cnt_run = cnt_q;
		keep    = 1'b0;
		is_err  = 1'b0;
		cur     = '0;
		for (int i = 0; i < 3; i++) begin
			is_err = (cand[i].kind == KIND_ERR);
			keep   = cand[i].vld && (is_err || cnt_run < CNT_W'(MAX_TOKEN_COUNT));
			cur    = '{tok_kind: cand[i].kind, tok_code: cand[i].code,
				start_line: cand[i].line, start_offset: cand[i].off,
				tok_length: cand[i].len, tok_index: is_err ? 10'd0 : 10'(cnt_run),
				last_of_run: 1'b0};
			if (keep) begin
				if (n_res == 2'd0) res0 = cur;
				else res1 = cur;
				n_res = n_res + 2'd1;
				if (!is_err) cnt_run = cnt_run + CNT_W'(1);
			end
		end
		if (n_res == 2'd1) res0.last_of_run = 1'b1;
		if (n_res == 2'd2) res1.last_of_run = 1'b1;
	end

	// control and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_IDLE;
			pch_q    <= 8'd0;
			line_q   <= 16'd1;
			off_q    <= 24'd0;
			soff_q   <= 24'd0;
			sline_q  <= 16'd1;
			len_q    <= 8'd0;
			pfx_q    <= 48'd0;
			cnt_q    <= '0;
			head_q   <= 2'd0;
			tail_q   <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (!src_stall) valid_s1 <= src_valid;
			if (adv) begin
				cnt_q <= cnt_run;
				if (eos) begin
					mode_q  <= M_IDLE;
					pch_q   <= 8'd0;
					line_q  <= 16'd1;
					off_q   <= 24'd0;
					soff_q  <= 24'd0;
					sline_q <= 16'd1;
					len_q   <= 8'd0;
					pfx_q   <= 48'd0;
				end else begin
					mode_q  <= mode_a;
					pch_q   <= pch_a;
					line_q  <= line_a;
					off_q   <= (off_q != 24'hFFFFFF) ? off_q + 24'd1 : off_q;
					soff_q  <= soff_a;
					sline_q <= sline_a;
					len_q   <= len_a;
					pfx_q   <= pfx_a;
				end
			end
			if (pop) head_q <= head_q + 2'd1;
			if (adv) tail_q <= tail_q + 2'(n_res);
			count_q <= count_q + ((adv) ? 3'(n_res) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) item_s1 <= src_data;
		if (adv && n_res != 2'd0) q_mem[tail_q] <= res0;
		if (adv && n_res == 2'd2) q_mem[tail_q + 2'd1] <= res1;
	end

endmodule
